/* hdl/mas_pkg.sv */
// shared types and constants of the memory admission scheduler
`default_nettype none

package mas_pkg;

    // payload widths
    localparam int ID_W  = 8;
    localparam int MEM_W = 16;
    localparam int JOB_W = ID_W + MEM_W;

    // queue depth defaults
    localparam int DEF_RUN_DEPTH  = 16;
    localparam int DEF_WAIT_DEPTH = 16;

    // pool size after reset
    localparam logic [MEM_W-1:0] RESET_TOTAL = 16'd1000;

    // at most this many events per request
    localparam int MAX_RESULTS = 18;
    localparam int ADMIT_W     = $clog2(MAX_RESULTS);
    localparam logic [ADMIT_W-1:0] KILL_ADMIT_CAP = ADMIT_W'(MAX_RESULTS - 1);

    // event codes
    typedef enum logic [2:0] {
        RES_QUEUED   = 3'd0,
        RES_ADMITTED = 3'd1,
        RES_KILLED   = 3'd2,
        RES_DROPPED  = 3'd3,
        RES_NONE     = 3'd4,
        RES_REJECTED = 3'd5
    } t_res;

    // request opcodes
    localparam logic OP_CREATE = 1'b0;
    localparam logic OP_KILL   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the request
        logic start;      // apply the request's own event
        logic admit;      // move the waiting head to the running queue
        logic emit;       // hand the held event to the output register
        logic emit_last;  // the event handed over closes the request
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_create;
        logic wait_full;
        logic head_fits;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

/* hdl/mas_in_if.sv */
// request channel of the memory admission scheduler
`default_nettype none

interface mas_in_if
    import mas_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             op;
    logic [ID_W-1:0]  job_id;
    logic [MEM_W-1:0] job_memory;

    modport source (output valid, op, job_id, job_memory, input ready);
    modport sink   (input valid, op, job_id, job_memory, output ready);
endinterface

`default_nettype wire

/* hdl/mas_out_if.sv */
// event channel of the memory admission scheduler
`default_nettype none

interface mas_out_if
    import mas_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [2:0]       event_res;
    logic [ID_W-1:0]  event_job_id;
    logic [MEM_W-1:0] event_job_memory;
    logic [MEM_W-1:0] free_after;
    logic             last;

    modport source (output valid, event_res, event_job_id, event_job_memory, free_after,
                    last, input ready);
    modport sink   (input valid, event_res, event_job_id, event_job_memory, free_after,
                    last, output ready);
endinterface

`default_nettype wire

/* hdl/memory_admission_scheduler.sv */
// top level of the memory admission scheduler
//
// Requests enter on i_in (valid/ready): op 0 creates a job {job_id, job_memory}
// in the waiting queue, op 1 kills the oldest running job. Each request yields
// one to 18 events on o_out (valid/ready), the final one flagged by last.
// A create gives a queued or rejected event and at most one admission; a kill
// gives a killed, dropped or nothing-to-kill event and then admits waiting jobs
// while they fit in free memory and the running queue has room.
// Sequence: after the transfer the request's own event is applied, then the job
// stores are read and the event is decided and handed to the output register;
// each further admission repeats the queue read and the decision, because the
// job stores have a registered read. A new request is taken once the sequencer
// is back in idle.
// The output register holds one event while the next is worked out; when the
// receiver stalls, the sequencer waits with the following event and no
// request is taken until the last one has been handed over.
// Reset (i_rst_n low, synchronous) empties both queues and sets free memory
// to 1000. A write on i_cfg_we loads free memory with i_cfg_data; write only
// while no request is in progress. Queue contents are kept.
`default_nettype none

module memory_admission_scheduler
    import mas_pkg::*;
#(
    parameter int RUN_DEPTH  = DEF_RUN_DEPTH,
    parameter int WAIT_DEPTH = DEF_WAIT_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [MEM_W-1:0] i_cfg_data,
    mas_in_if.sink                i_in,
    mas_out_if.source             o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    // sequencer
    mas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // queues and event path
    mas_dp #(
        .RUN_DEPTH  (RUN_DEPTH),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_op               (i_in.op),
        .i_job_id           (i_in.job_id),
        .i_job_memory       (i_in.job_memory),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_event_res        (o_out.event_res),
        .o_event_job_id     (o_out.event_job_id),
        .o_event_job_memory (o_out.event_job_memory),
        .o_free_after       (o_out.free_after),
        .o_last             (o_out.last)
    );

`ifndef SYNTHESIS
    // an event is flagged last only when the sequencer goes back to accepting
    a_last_then_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit && w_cmd.emit_last |=> w_in_ready)
        else $error("last event without return to idle");
`endif

endmodule

`default_nettype wire

/* hdl/mas_ctrl.sv */
// sequencing state machine of the memory admission scheduler
`default_nettype none

module mas_ctrl
    import mas_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_FETCH,
        ST_CHECK
    } t_state;

    t_state               r_state;
    logic                 r_ready;
    logic [ADMIT_W-1:0]   r_admit_left;
    logic                 w_more;

    assign o_in_ready = r_ready;
    assign w_more     = (r_admit_left != '0) && i_stat.head_fits;

    // commands decoded from state
    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = r_ready && i_in_valid;
        o_cmd.start     = (r_state == ST_START);
        o_cmd.emit      = (r_state == ST_CHECK) && i_stat.out_free;
        o_cmd.emit_last = !w_more;
        o_cmd.admit     = (r_state == ST_CHECK) && i_stat.out_free && w_more;
    end

    // state, ready and admission budget
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ready      <= 1'b1;
            r_admit_left <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (r_ready && i_in_valid) begin
                        r_ready <= 1'b0;
                        r_state <= ST_START;
                    end
                end
                ST_START: begin
                    // a create may admit once, a kill up to one below the event cap
                    if (i_stat.is_create) begin
                        r_admit_left <= i_stat.wait_full ? '0 : ADMIT_W'(1);
                    end else begin
                        r_admit_left <= KILL_ADMIT_CAP;
                    end
                    r_state <= ST_FETCH;
                end
                ST_FETCH: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (i_stat.out_free) begin
                        if (w_more) begin
                            r_admit_left <= r_admit_left - ADMIT_W'(1);
                            r_state      <= ST_FETCH;
                        end else begin
                            r_ready <= 1'b1;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // no request is taken while one is in progress
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE))
        else $error("ready outside idle");

    // an accepted request always starts next cycle
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_START) && !o_in_ready)
        else $error("accepted request did not start");
`endif

endmodule

`default_nettype wire

/* hdl/mas_dp.sv */
// queues, free-memory count and event registers of the memory admission scheduler
`default_nettype none

module mas_dp
    import mas_pkg::*;
#(
    parameter int RUN_DEPTH  = DEF_RUN_DEPTH,
    parameter int WAIT_DEPTH = DEF_WAIT_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [MEM_W-1:0] i_cfg_data,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_stat              o_stat,
    input  wire logic             i_op,
    input  wire logic [ID_W-1:0]  i_job_id,
    input  wire logic [MEM_W-1:0] i_job_memory,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic [2:0]            o_event_res,
    output logic [ID_W-1:0]       o_event_job_id,
    output logic [MEM_W-1:0]      o_event_job_memory,
    output logic [MEM_W-1:0]      o_free_after,
    output logic                  o_last
);

    localparam int RUN_AW  = $clog2(RUN_DEPTH);
    localparam int RUN_CW  = $clog2(RUN_DEPTH + 1);
    localparam int WAIT_AW = $clog2(WAIT_DEPTH);
    localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);

    // job stores, {id, memory}
    logic [JOB_W-1:0]   run_mem  [RUN_DEPTH];
    logic [JOB_W-1:0]   wait_mem [WAIT_DEPTH];

    logic [RUN_AW-1:0]  r_run_head;
    logic [RUN_CW-1:0]  r_run_count;
    logic [WAIT_AW-1:0] r_wait_head;
    logic [WAIT_CW-1:0] r_wait_count;
    logic [JOB_W-1:0]   r_run_rd;
    logic [JOB_W-1:0]   r_wait_rd;
    logic [MEM_W-1:0]   r_free;

    // captured request
    logic               r_op;
    logic [JOB_W-1:0]   r_job;

    // event held until it is known whether another follows
    t_res               r_pend_res;
    logic [JOB_W-1:0]   r_pend_job;
    logic [MEM_W-1:0]   r_pend_free;

    // output register
    logic               r_out_valid;
    t_res               r_out_res;
    logic [JOB_W-1:0]   r_out_job;
    logic [MEM_W-1:0]   r_out_free;
    logic               r_out_last;

    logic               w_run_full;
    logic               w_wait_full;
    logic [RUN_AW:0]    w_run_sum;
    logic [RUN_AW-1:0]  w_run_tail;
    logic [WAIT_AW:0]   w_wait_sum;
    logic [WAIT_AW-1:0] w_wait_tail;
    logic [RUN_AW-1:0]  w_run_head_inc;
    logic [WAIT_AW-1:0] w_wait_head_inc;
    logic [MEM_W:0]     w_kill_sum;
    logic [MEM_W-1:0]   w_kill_free;
    logic [MEM_W-1:0]   w_admit_free;
    logic               w_head_fits;
    logic               w_wait_we;
    logic               w_run_we;

    // pointer arithmetic with wrap at any depth
    assign w_run_full  = (r_run_count == RUN_CW'(RUN_DEPTH));
    assign w_wait_full = (r_wait_count == WAIT_CW'(WAIT_DEPTH));
    assign w_run_sum   = {1'b0, r_run_head} + (RUN_AW+1)'(r_run_count);
    assign w_run_tail  = (w_run_sum >= (RUN_AW+1)'(RUN_DEPTH))
                       ? RUN_AW'(w_run_sum - (RUN_AW+1)'(RUN_DEPTH)) : RUN_AW'(w_run_sum);
    assign w_wait_sum  = {1'b0, r_wait_head} + (WAIT_AW+1)'(r_wait_count);
    assign w_wait_tail = (w_wait_sum >= (WAIT_AW+1)'(WAIT_DEPTH))
                       ? WAIT_AW'(w_wait_sum - (WAIT_AW+1)'(WAIT_DEPTH))
                       : WAIT_AW'(w_wait_sum);
    assign w_run_head_inc  = (r_run_head == RUN_AW'(RUN_DEPTH - 1))
                           ? '0 : r_run_head + RUN_AW'(1);
    assign w_wait_head_inc = (r_wait_head == WAIT_AW'(WAIT_DEPTH - 1))
                           ? '0 : r_wait_head + WAIT_AW'(1);

    // returned memory saturates at full scale
    assign w_kill_sum   = {1'b0, r_free} + {1'b0, r_run_rd[MEM_W-1:0]};
    assign w_kill_free  = w_kill_sum[MEM_W] ? '1 : w_kill_sum[MEM_W-1:0];
    assign w_admit_free = r_free - r_wait_rd[MEM_W-1:0];

    assign w_head_fits = (r_wait_count != '0) && !w_run_full
                       && (r_wait_rd[MEM_W-1:0] <= r_free);

    assign w_wait_we = i_cmd.start && (r_op == OP_CREATE) && !w_wait_full;
    assign w_run_we  = i_cmd.admit;

    // status to the controller
    always_comb begin
        o_stat           = '0;
        o_stat.is_create = (r_op == OP_CREATE);
        o_stat.wait_full = w_wait_full;
        o_stat.head_fits = w_head_fits;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // job stores with registered head read
    always_ff @(posedge i_clk) begin
        if (w_run_we) begin
            run_mem[w_run_tail] <= r_wait_rd;
        end
        r_run_rd <= run_mem[r_run_head];
    end

    always_ff @(posedge i_clk) begin
        if (w_wait_we) begin
            wait_mem[w_wait_tail] <= r_job;
        end
        r_wait_rd <= wait_mem[r_wait_head];
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_job <= {i_job_id, i_job_memory};
        end
    end

    // queue pointers, counts and free memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_head   <= '0;
            r_run_count  <= '0;
            r_wait_head  <= '0;
            r_wait_count <= '0;
            r_free       <= RESET_TOTAL;
        end else if (i_cfg_we) begin
            r_free <= i_cfg_data;
        end else if (i_cmd.start) begin
            if (r_op == OP_CREATE) begin
                if (!w_wait_full) begin
                    r_wait_count <= r_wait_count + WAIT_CW'(1);
                end
            end else if (r_run_count != '0) begin
                r_run_head  <= w_run_head_inc;
                r_run_count <= r_run_count - RUN_CW'(1);
                r_free      <= w_kill_free;
            end else if (r_wait_count != '0) begin
                r_wait_head  <= w_wait_head_inc;
                r_wait_count <= r_wait_count - WAIT_CW'(1);
            end
        end else if (i_cmd.admit) begin
            r_wait_head  <= w_wait_head_inc;
            r_wait_count <= r_wait_count - WAIT_CW'(1);
            r_run_count  <= r_run_count + RUN_CW'(1);
            r_free       <= w_admit_free;
        end
    end

    // held event
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pend_free <= r_free;
            r_pend_job  <= r_job;
            if (r_op == OP_CREATE) begin
                r_pend_res <= w_wait_full ? RES_REJECTED : RES_QUEUED;
            end else if (r_run_count != '0) begin
                r_pend_res  <= RES_KILLED;
                r_pend_job  <= r_run_rd;
                r_pend_free <= w_kill_free;
            end else if (r_wait_count != '0) begin
                r_pend_res <= RES_DROPPED;
                r_pend_job <= r_wait_rd;
            end else begin
                r_pend_res <= RES_NONE;
                r_pend_job <= '0;
            end
        end else if (i_cmd.admit) begin
            r_pend_res  <= RES_ADMITTED;
            r_pend_job  <= r_wait_rd;
            r_pend_free <= w_admit_free;
        end
    end

    // output register, refilled on the transfer cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_res  <= r_pend_res;
            r_out_job  <= r_pend_job;
            r_out_free <= r_pend_free;
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_res        = r_out_res;
    assign o_event_job_id     = r_out_job[JOB_W-1:MEM_W];
    assign o_event_job_memory = r_out_job[MEM_W-1:0];
    assign o_free_after       = r_out_free;
    assign o_last             = r_out_last;

`ifndef SYNTHESIS
    // admission only when the head job fits and the running queue has room
    a_admit_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.admit |-> w_head_fits)
        else $error("admission without room");

    // admission moves exactly one job between the queues
    a_admit_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.admit && !i_cfg_we |=> (r_run_count == $past(r_run_count) + RUN_CW'(1))
            && (r_wait_count == $past(r_wait_count) - WAIT_CW'(1)))
        else $error("admission count mismatch");

    // the output register is never overwritten while an event waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("event overwritten");
`endif

endmodule

`default_nettype wire

/* tb/mas_sched_tracker_pkg.sv */
// expected-event tracker for the memory admission scheduler testbench
`timescale 1ns / 100ps

package mas_sched_tracker_pkg;
    import mas_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [MEM_W-1:0] mem;
    } sched_job_t;

    typedef struct packed {
        t_res             res;
        logic [ID_W-1:0]  id;
        logic [MEM_W-1:0] mem;
        logic [MEM_W-1:0] free_after;
        logic             last;
    } sched_event_t;

    localparam int REPORT_LIMIT = 10;

    class sched_tracker;
        logic [MEM_W-1:0] total_mem;
        logic [MEM_W-1:0] free_mem;
        sched_job_t       running_jobs[$];
        sched_job_t       waiting_jobs[$];
        sched_event_t     pending_events[$];
        sched_event_t     burst[$];
        int unsigned      mismatches;
        int unsigned      leftover;
        int unsigned      requests;
        int unsigned      events_seen;
        int unsigned      longest_burst;
        int unsigned      code_hits[6];

        function new();
            total_mem     = RESET_TOTAL;
            free_mem      = RESET_TOTAL;
            mismatches    = 0;
            leftover      = 0;
            requests      = 0;
            events_seen   = 0;
            longest_burst = 0;
            foreach (code_hits[i]) code_hits[i] = 0;
        endfunction

        // pool size write reloads free memory, queues stay as they are
        function void load_total(logic [MEM_W-1:0] value);
            total_mem = value;
            free_mem  = value;
        endfunction

        function bit head_fits();
            return waiting_jobs.size() > 0 && running_jobs.size() < DEF_RUN_DEPTH &&
                   waiting_jobs[0].mem <= free_mem;
        endfunction

        function void emit(t_res code, sched_job_t job);
            sched_event_t ev;
            ev.res        = code;
            ev.id         = job.id;
            ev.mem        = job.mem;
            ev.free_after = free_mem;
            ev.last       = 1'b0;
            burst.push_back(ev);
        endfunction

        function void admit_head();
            sched_job_t job;
            job = waiting_jobs.pop_front();
            running_jobs.push_back(job);
            free_mem = free_mem - job.mem;
            emit(RES_ADMITTED, job);
        endfunction

        // work out the events that one accepted request causes
        function void note_request(logic op, logic [ID_W-1:0] id, logic [MEM_W-1:0] mem);
            sched_job_t   job;
            sched_job_t   gone;
            sched_event_t tail;
            logic [MEM_W:0] sum;
            job.id  = id;
            job.mem = mem;
            burst.delete();
            requests++;
            if (op == OP_CREATE) begin
                if (waiting_jobs.size() >= DEF_WAIT_DEPTH) begin
                    emit(RES_REJECTED, job);
                end else begin
                    waiting_jobs.push_back(job);
                    emit(RES_QUEUED, job);
                    if (head_fits()) admit_head();
                end
            end else begin
                if (running_jobs.size() > 0) begin
                    gone     = running_jobs.pop_front();
                    sum      = {1'b0, free_mem} + {1'b0, gone.mem};
                    free_mem = sum[MEM_W] ? {MEM_W{1'b1}} : sum[MEM_W-1:0];
                    emit(RES_KILLED, gone);
                end else if (waiting_jobs.size() > 0) begin
                    gone = waiting_jobs.pop_front();
                    emit(RES_DROPPED, gone);
                end else begin
                    emit(RES_NONE, '0);
                end
                // refill the running queue while the waiting head fits
                while (burst.size() < MAX_RESULTS && head_fits()) admit_head();
            end
            tail = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
            if (burst.size() > longest_burst) longest_burst = burst.size();
            foreach (burst[i]) pending_events.push_back(burst[i]);
        endfunction

        function void report_mismatch(string what, sched_event_t want, sched_event_t got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch %0d (%s): expected res %0d id %02h mem %04h free %04h last %0b,",
                         mismatches, what, want.res, want.id, want.mem, want.free_after,
                         want.last,
                         " got res %0d id %02h mem %04h free %04h last %0b",
                         got.res, got.id, got.mem, got.free_after, got.last);
        endfunction

        // compare one event transfer with the oldest expectation
        function void check_event(sched_event_t got);
            sched_event_t want;
            events_seen++;
            if (pending_events.size() == 0) begin
                report_mismatch("no event pending", '0, got);
                return;
            end
            want = pending_events.pop_front();
            if (got.res !== want.res || got.id !== want.id || got.mem !== want.mem ||
                got.free_after !== want.free_after || got.last !== want.last)
                report_mismatch("field", want, got);
            else if (want.res <= RES_REJECTED)
                code_hits[want.res]++;
        endfunction

        function int unsigned outstanding();
            return pending_events.size();
        endfunction

        function void close_out();
            leftover = pending_events.size();
            if (leftover != 0)
                $display("%0d expected events never arrived", leftover);
        endfunction

        function int unsigned failures();
            return mismatches + leftover;
        endfunction
    endclass

endpackage

/* tb/memory_admission_scheduler_test.sv */
// testbench top for the memory admission scheduler: directed and random requests
`timescale 1ns / 100ps

module memory_admission_scheduler_test;
    import mas_pkg::*;
    import mas_sched_tracker_pkg::*;

    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LIMIT_CYCLES  = 1_200_000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we;
    logic [MEM_W-1:0] i_cfg_data;

    bit          calm_mode    = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned cfg_writes   = 0;

    sched_tracker tracker = new();

    mas_in_if  req_if ();
    mas_out_if evt_if ();

    memory_admission_scheduler u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_if),
        .o_out      (evt_if)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // job demand scaled to the pool, with zero, maximum and full-range values mixed in
    function automatic logic [MEM_W-1:0] pick_demand(logic [MEM_W-1:0] total);
        int roll;
        int cap;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 14) return {MEM_W{1'b1}};
        if (roll < 24) return MEM_W'($urandom_range(0, 65535));
        cap = total / 6;
        if (cap < 2) cap = 2;
        return MEM_W'($urandom_range(0, cap));
    endfunction

    // offer one request and wait for its transfer
    task automatic send_request(input logic op, input logic [ID_W-1:0] id,
                                input logic [MEM_W-1:0] mem);
        int gap;
        gap = calm_mode ? 0 : (($urandom_range(0, 1) == 0) ? 0 : pick_gap());
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= op;
        req_if.job_id     <= id;
        req_if.job_memory <= mem;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        tracker.note_request(op, id, mem);
    endtask

    // stop offering and let every expected event come out
    task automatic settle(input int extra);
        req_if.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_total(input logic [MEM_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.load_total(value);
        cfg_writes++;
    endtask

    // event receiver: random stalls, one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        evt_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                evt_if.ready <= 1'b0;
                stall_left--;
            end else begin
                evt_if.ready <= 1'b1;
                if (!calm_mode && $urandom_range(0, 99) < 30) stall_left = pick_gap();
            end
        end
    end

    // event monitor
    always @(posedge i_clk) begin
        sched_event_t got;
        if (i_rst_n && evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
            got.res        = t_res'(evt_if.event_res);
            got.id         = evt_if.event_job_id;
            got.mem        = evt_if.event_job_memory;
            got.free_after = evt_if.free_after;
            got.last       = evt_if.last;
            tracker.check_event(got);
        end
    end

    // stimulus
    initial begin
        logic [MEM_W-1:0] total;
        req_if.valid      <= 1'b0;
        req_if.op         <= OP_CREATE;
        req_if.job_id     <= '0;
        req_if.job_memory <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // empty kill, zero-demand job, oversize job blocking the head, drop then admit
        send_request(OP_KILL, ID_W'($urandom), MEM_W'($urandom));
        send_request(OP_CREATE, 8'h00, 16'h0000);
        send_request(OP_CREATE, 8'hFF, 16'hFFFF);
        send_request(OP_CREATE, 8'hA5, 16'd1000);
        send_request(OP_KILL, ID_W'($urandom), MEM_W'($urandom));
        send_request(OP_KILL, ID_W'($urandom), MEM_W'($urandom));

        // empty pool: fill the waiting queue, then one create too many
        settle(SETTLE_CYCLES);
        write_total('0);
        for (int i = 0; i < DEF_WAIT_DEPTH; i++)
            send_request(OP_CREATE, ID_W'(8'h10 + i), MEM_W'(i + 1));
        send_request(OP_CREATE, 8'h5A, 16'h1234);

        // full pool: kill saturates free memory, mass admission fills the running queue
        settle(SETTLE_CYCLES);
        write_total({MEM_W{1'b1}});
        send_request(OP_KILL, ID_W'($urandom), MEM_W'($urandom));
        send_request(OP_CREATE, 8'hC3, 16'h0007);
        send_request(OP_KILL, ID_W'($urandom), MEM_W'($urandom));

        // random phases over several pool sizes
        for (int p = 0; p < PHASES; p++) begin
            settle(SETTLE_CYCLES);
            case (p)
                0: total = RESET_TOTAL;
                1: total = '0;
                2: total = {MEM_W{1'b1}};
                3: total = 16'd1;
                5: total = 16'd300;
                default: total = MEM_W'($urandom_range(0, 65535));
            endcase
            write_total(total);
            calm_mode = (p == 3);
            if (p == 2) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 40)
                    send_request(OP_KILL, ID_W'($urandom), MEM_W'($urandom));
                else
                    send_request(OP_CREATE, ID_W'($urandom_range(0, 255)), pick_demand(total));
            end
        end
        calm_mode = 1'b0;

        settle(DRAIN_CYCLES);
        tracker.close_out();
        $display("%0d requests, %0d events over %0d pool sizes; longest burst %0d events",
                 tracker.requests, tracker.events_seen, cfg_writes, tracker.longest_burst);
        $display("queued %0d admitted %0d killed %0d dropped %0d none %0d rejected %0d",
                 tracker.code_hits[RES_QUEUED], tracker.code_hits[RES_ADMITTED],
                 tracker.code_hits[RES_KILLED], tracker.code_hits[RES_DROPPED],
                 tracker.code_hits[RES_NONE], tracker.code_hits[RES_REJECTED]);
        if (tracker.failures() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("timeout, %0d events still expected", tracker.outstanding());
        $display("tb: failure");
        $finish;
    end

endmodule
